// File: hdl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and tables for the calendar day difference block
// Month tables, reciprocal constant for divide by 100, datapath widths.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int QuoW   = 8;                // year / 100 fits in 8 bits
  localparam int PartW  = 12;               // p/4 - p/100 + p/400
  localparam int MaddW  = 9;                // month start plus leap day
  localparam int OrdW   = 23;               // ordinal day count
  localparam int CountW = 22;               // day_count field

  // floor(x / 100) == (x * Div100Mul) >> Div100Shift for x < 2**14
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;
  localparam int ProdW       = YearW + 13;

  localparam logic [YearW-1:0]  YearDefault  = YearW'(2000);
  localparam logic [MonW-1:0]   MonJan       = MonW'(1);
  localparam logic [MonW-1:0]   MonFeb       = MonW'(2);
  localparam logic [MonW-1:0]   MonDec       = MonW'(12);
  localparam logic [CountW-1:0] DayCountMax  = {CountW{1'b1}};

  typedef logic [OrdW-1:0]   ord_t;
  typedef logic [YearW-1:0]  year_t;
  typedef logic [QuoW-1:0]   quo_t;

  // days in the months before month m (m already normalized to 1..12)
  function automatic logic [MaddW-1:0] month_start(input logic [MonW-1:0] m);
    logic [MaddW-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] r;
    unique case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/calendar_day_difference.sv
// ----------------------------------------------------------------------------
// calendar_day_difference: absolute day count between two Gregorian dates
// start is staged through to out_valid; one date pair accepted per cycle.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
// Synchronous active-low reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module calendar_day_difference
  import cdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DayW-1:0]   in_first_day,
  input  logic [MonW-1:0]   in_first_month,
  input  logic [YearW-1:0]  in_first_year,
  input  logic [DayW-1:0]   in_second_day,
  input  logic [MonW-1:0]   in_second_month,
  input  logic [YearW-1:0]  in_second_year,
  output logic              out_valid,
  output logic [CountW-1:0] out_day_count
);

  // Pipeline:
  //   stage 1  normalize month/year, p = year-1, reciprocal multiplies for
  //            year/100, p/100 and p/400
  //   stage 2  leap test, day clamp, 365*p, leap-count partial sum,
  //            month offset
  //   stage 3  ordinal = 365*p + leap days + month offset + day
  //   stage 4  |a - b| with saturation, output register
  // Both dates run in parallel lanes (index 0 first, 1 second).

  logic              accept;
  logic [DayW-1:0]   in_day  [2];
  logic [MonW-1:0]   in_mon  [2];
  logic [YearW-1:0]  in_year [2];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign in_day[0]  = in_first_day;
  assign in_mon[0]  = in_first_month;
  assign in_year[0] = in_first_year;
  assign in_day[1]  = in_second_day;
  assign in_mon[1]  = in_second_month;
  assign in_year[1] = in_second_year;

  // ---------------- stage 1 ----------------
  logic              s1_vld_r, s1_vld_nxt;
  logic [DayW-1:0]   s1_day_r  [2], s1_day_nxt  [2];
  logic [MonW-1:0]   s1_mon_r  [2], s1_mon_nxt  [2];
  year_t             s1_year_r [2], s1_year_nxt [2];
  year_t             s1_prev_r [2], s1_prev_nxt [2];
  quo_t              s1_qy_r   [2], s1_qy_nxt   [2];   // year / 100
  quo_t              s1_qp_r   [2], s1_qp_nxt   [2];   // p / 100
  quo_t              s1_qp4_r  [2], s1_qp4_nxt  [2];   // p / 400

  always_comb begin
    logic [ProdW-1:0] prod_y, prod_p, prod_p4;
    year_t            yr, pv;
    s1_vld_nxt = accept;
    for (int i = 0; i < 2; i++) begin
      // month outside 1..12 is January, year zero is 2000
      s1_mon_nxt[i] = (in_mon[i] == '0 || in_mon[i] > MonDec) ? MonJan : in_mon[i];
      yr            = (in_year[i] == '0) ? YearDefault : in_year[i];
      pv            = yr - year_t'(1);
      prod_y        = ProdW'(yr) * ProdW'(Div100Mul);
      prod_p        = ProdW'(pv) * ProdW'(Div100Mul);
      prod_p4       = ProdW'(pv[YearW-1:2]) * ProdW'(Div100Mul);
      s1_day_nxt[i]  = in_day[i];
      s1_year_nxt[i] = yr;
      s1_prev_nxt[i] = pv;
      s1_qy_nxt[i]   = prod_y[Div100Shift +: QuoW];
      s1_qp_nxt[i]   = prod_p[Div100Shift +: QuoW];
      s1_qp4_nxt[i]  = prod_p4[Div100Shift +: QuoW];
    end
  end

  // ---------------- stage 2 ----------------
  logic              s2_vld_r, s2_vld_nxt;
  ord_t              s2_p365_r [2], s2_p365_nxt [2];
  logic [PartW-1:0]  s2_part_r [2], s2_part_nxt [2];
  logic [MaddW-1:0]  s2_madd_r [2], s2_madd_nxt [2];
  logic [DayW-1:0]   s2_day_r  [2], s2_day_nxt  [2];

  always_comb begin
    logic            leap, cent;
    year_t           hund;
    logic [DayW-1:0] len;
    s2_vld_nxt = s1_vld_r;
    for (int i = 0; i < 2; i++) begin
      hund = year_t'(s1_qy_r[i]) * year_t'(100);
      cent = (hund == s1_year_r[i]);
      leap = (s1_year_r[i][1:0] == 2'b00 && !cent) ||
             (cent && s1_qy_r[i][1:0] == 2'b00);
      len  = month_len(s1_mon_r[i], leap);
      // day past end of month becomes the first; day zero stays zero
      s2_day_nxt[i]  = (s1_day_r[i] > len) ? DayW'(1) : s1_day_r[i];
      s2_p365_nxt[i] = OrdW'(s1_prev_r[i]) * OrdW'(365);
      s2_part_nxt[i] = PartW'(s1_prev_r[i][YearW-1:2]) - PartW'(s1_qp_r[i])
                       + PartW'(s1_qp4_r[i]);
      s2_madd_nxt[i] = month_start(s1_mon_r[i])
                       + MaddW'(leap && s1_mon_r[i] > MonFeb);
    end
  end

  // ---------------- stage 3 ----------------
  logic s3_vld_r, s3_vld_nxt;
  ord_t s3_ord_r [2], s3_ord_nxt [2];

  always_comb begin
    s3_vld_nxt = s2_vld_r;
    for (int i = 0; i < 2; i++) begin
      s3_ord_nxt[i] = s2_p365_r[i] + OrdW'(s2_part_r[i]) + OrdW'(s2_madd_r[i])
                      + OrdW'(s2_day_r[i]);
    end
  end

  // ---------------- stage 4 ----------------
  logic              s4_vld_r, s4_vld_nxt;
  logic [CountW-1:0] s4_cnt_r, s4_cnt_nxt;

  always_comb begin
    ord_t diff;
    s4_vld_nxt = s3_vld_r;
    diff = (s3_ord_r[0] > s3_ord_r[1]) ? (s3_ord_r[0] - s3_ord_r[1])
                                       : (s3_ord_r[1] - s3_ord_r[0]);
    // saturate at the field's maximum
    s4_cnt_nxt = diff[OrdW-1] ? DayCountMax : diff[CountW-1:0];
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      s1_day_r[i]  <= s1_day_nxt[i];
      s1_mon_r[i]  <= s1_mon_nxt[i];
      s1_year_r[i] <= s1_year_nxt[i];
      s1_prev_r[i] <= s1_prev_nxt[i];
      s1_qy_r[i]   <= s1_qy_nxt[i];
      s1_qp_r[i]   <= s1_qp_nxt[i];
      s1_qp4_r[i]  <= s1_qp4_nxt[i];
      s2_p365_r[i] <= s2_p365_nxt[i];
      s2_part_r[i] <= s2_part_nxt[i];
      s2_madd_r[i] <= s2_madd_nxt[i];
      s2_day_r[i]  <= s2_day_nxt[i];
      s3_ord_r[i]  <= s3_ord_nxt[i];
    end
    s4_cnt_r <= s4_cnt_nxt;
  end

  // valid bits, synchronous reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  assign out_valid     = s4_vld_r;
  assign out_day_count = s4_cnt_r;

endmodule

// File: tb/day_count_board_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// day_count_board_pkg: day count predictor and result board
// Works out the day distance between two dates the same way the block
// should, queues it per accepted word, and checks each result word in order.
// ----------------------------------------------------------------------------
package day_count_board_pkg;

  import cdd_pkg::*;

  localparam int unsigned DaysBefore [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam int unsigned DaysIn [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // m must already be 1..12
  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    if (m == 2 && leap) return 29;
    return DaysIn[m-1];
  endfunction

  // ordinal day number of a date after normalization
  function automatic int unsigned day_ordinal(input logic [DayW-1:0] d,
                                              input logic [MonW-1:0] m,
                                              input logic [YearW-1:0] y);
    int unsigned dd, mm, yy, p, total;
    bit leap;
    dd = d;
    mm = m;
    yy = y;
    if (mm < 1 || mm > 12) mm = 1;
    if (yy == 0) yy = 2000;
    leap = leap_year(yy);
    if (dd > month_length(mm, leap)) dd = 1;   // day zero stays zero
    p = yy - 1;
    total = 365 * p + p / 4 - p / 100 + p / 400;
    total += DaysBefore[mm-1];
    if (leap && mm > 2) total += 1;
    return total + dd;
  endfunction

  class day_count_board;
    logic [CountW-1:0] pending_counts [$];
    int unsigned fail_count;
    int unsigned noted_count;
    int unsigned checked_count;
    int unsigned saturated_count;

    function void note_dates(input logic [DayW-1:0] d1, input logic [MonW-1:0] m1,
                             input logic [YearW-1:0] y1, input logic [DayW-1:0] d2,
                             input logic [MonW-1:0] m2, input logic [YearW-1:0] y2);
      int unsigned a, b, diff;
      a = day_ordinal(d1, m1, y1);
      b = day_ordinal(d2, m2, y2);
      diff = (a > b) ? a - b : b - a;
      if (diff > DayCountMax) diff = DayCountMax;
      pending_counts.push_back(CountW'(diff));
      noted_count++;
    endfunction

    function void check_count(input logic [CountW-1:0] got);
      logic [CountW-1:0] want;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected day_count word, expected none, got %0d", $time, got);
        fail_count++;
        return;
      end
      want = pending_counts.pop_front();
      checked_count++;
      if (want == DayCountMax) saturated_count++;
      if (got !== want) begin
        $display("%0t: day_count mismatch, expected %0d, got %0d", $time, want, got);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_counts.size();
    endfunction
  endclass

endpackage

// File: tb/calendar_day_difference_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_day_difference_test: self-checking bench for the day difference
// Drives date pairs through the command port (directed corners, then random
// words with idle bursts), predicts every day_count and checks results in
// order as they come out of the pipeline.
// ----------------------------------------------------------------------------
module calendar_day_difference_test;

  import cdd_pkg::*;
  import day_count_board_pkg::*;

  localparam int RandomWords   = 1050;
  localparam int QuietTail     = 150;   // last words go back to back
  localparam int WatchdogLimit = 500;   // cycles with no word moving
  localparam int DrainCycles   = 8;     // pipeline is 4 deep

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DayW-1:0]   in_first_day;
  logic [MonW-1:0]   in_first_month;
  logic [YearW-1:0]  in_first_year;
  logic [DayW-1:0]   in_second_day;
  logic [MonW-1:0]   in_second_month;
  logic [YearW-1:0]  in_second_year;
  logic              out_valid;
  logic [CountW-1:0] out_day_count;

  day_count_board board;
  int unsigned idle_cycles;

  calendar_day_difference uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_first_day    (in_first_day),
    .in_first_month  (in_first_month),
    .in_first_year   (in_first_year),
    .in_second_day   (in_second_day),
    .in_second_month (in_second_month),
    .in_second_year  (in_second_year),
    .out_valid       (out_valid),
    .out_day_count   (out_day_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: everything is sampled at the rising edge, before the block's
  // own updates land. The input word is noted before the result is checked
  // so that results line up with their words whatever the latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        board.note_dates(in_first_day, in_first_month, in_first_year,
                         in_second_day, in_second_month, in_second_year);
      if (out_valid)
        board.check_count(out_day_count);
    end
  end

  // Watchdog: any word moving in either direction clears the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, WatchdogLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Put one date pair on the port and hold it until the block takes it.
  // start is left high so a following word goes out back to back.
  task automatic send_dates(input logic [DayW-1:0] d1, input logic [MonW-1:0] m1,
                            input logic [YearW-1:0] y1, input logic [DayW-1:0] d2,
                            input logic [MonW-1:0] m2, input logic [YearW-1:0] y2);
    start           <= 1'b1;
    in_first_day    <= d1;
    in_first_month  <= m1;
    in_first_year   <= y1;
    in_second_day   <= d2;
    in_second_month <= m2;
    in_second_year  <= y2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle burst: start low, junk on the fields to show they are ignored.
  task automatic pause_input(input int cycles);
    start           <= 1'b0;
    in_first_day    <= DayW'($urandom);
    in_first_year   <= YearW'($urandom);
    in_second_month <= MonW'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly well-formed dates; the rest are raw field values, which hit the
  // month, year and day normalization and the years past 9999.
  task automatic pick_date(output logic [DayW-1:0] d, output logic [MonW-1:0] m,
                           output logic [YearW-1:0] y);
    int unsigned yy, mm;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0:       yy = $urandom_range(1, 2500);
        1:       yy = $urandom_range(1896, 2104);   // dense around centuries
        2:       yy = $urandom_range(1, 9999);
        default: yy = $urandom_range(1, 16383);
      endcase
      mm = $urandom_range(1, 12);
      y  = YearW'(yy);
      m  = MonW'(mm);
      d  = DayW'($urandom_range(1, month_length(mm, leap_year(yy))));
    end else begin
      d = DayW'($urandom);
      m = MonW'($urandom);
      y = YearW'($urandom);
    end
  endtask

  initial begin
    logic [DayW-1:0]  d1, d2;
    logic [MonW-1:0]  m1, m2;
    logic [YearW-1:0] y1, y2;

    board = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_first_day    <= '0;
    in_first_month  <= '0;
    in_first_year   <= '0;
    in_second_day   <= '0;
    in_second_month <= '0;
    in_second_year  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed corners ----
    send_dates(0, 0, 0, 0, 0, 0);                  // all zero: Jan 0, 2000 both
    send_dates(31, 15, 16383, 0, 0, 0);            // all fields at max vs zero
    send_dates(5, 6, 2021, 5, 6, 2021);            // same date gives zero
    send_dates(31, 12, 1999, 1, 1, 2000);          // across new year
    send_dates(29, 2, 2000, 1, 3, 2000);           // leap day, 400 rule
    send_dates(29, 2, 1900, 1, 3, 1900);           // not leap, 100 rule: day to 1
    send_dates(29, 2, 2023, 28, 2, 2024);          // plain non-leap year
    send_dates(30, 2, 2024, 1, 3, 2024);           // past end of leap Feb
    send_dates(31, 4, 2010, 30, 4, 2010);          // 31st in a 30 day month
    send_dates(0, 3, 2024, 29, 2, 2024);           // day zero is day before 1st
    send_dates(15, 13, 2005, 15, 1, 2005);         // month 13 taken as Jan
    send_dates(1, 15, 1, 1, 0, 1);                 // month 15 and 0
    send_dates(1, 1, 0, 1, 1, 2000);               // year zero is 2000
    send_dates(1, 3, 2100, 28, 2, 2100);           // 2100 not leap
    send_dates(1, 3, 2400, 28, 2, 2400);           // 2400 leap
    send_dates(1, 1, 1, 31, 12, 9999);             // full four-digit span
    send_dates(0, 1, 1, 31, 12, 16383);            // saturates
    send_dates(31, 12, 16383, 1, 1, 4000);         // past full scale, also saturates
    send_dates(31, 12, 10000, 1, 1, 9999);         // years past 9999
    send_dates(31, 1, 2020, 1, 12, 2020);          // month start table ends
    send_dates(30, 11, 1600, 31, 10, 1601);
    pause_input(3);
    send_dates(21, 10, 10922, 10, 5, 5461);        // alternating year bits
    send_dates(10, 5, 5461, 21, 10, 10922);        // swapped order

    // ---- random words ----
    for (int i = 0; i < RandomWords; i++) begin
      pick_date(d1, m1, y1);
      pick_date(d2, m2, y2);
      if ($urandom_range(0, 2) == 0) y2 = y1;      // near dates, small counts
      send_dates(d1, m1, y1, d2, m2, y2);
      if (i < RandomWords - QuietTail && $urandom_range(0, 3) == 0)
        pause_input($urandom_range(1, 15));
    end
    start <= 1'b0;

    // drain the pipeline, then watch DrainCycles more cycles for stray words
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d date pairs, checked %0d day counts (%0d at full scale)",
             board.noted_count, board.checked_count, board.saturated_count);
    if (board.fail_count == 0 && board.outstanding() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: calendar_day_difference.f
hdl/cdd_pkg.sv
hdl/calendar_day_difference.sv
tb/day_count_board_pkg.sv
tb/calendar_day_difference_test.sv
